FILE: rtl/pfu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pfu_pkg;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_SETUP,
        ST_READ,
        ST_LAST,
        ST_PUSH
    } state_t;

    localparam logic [2:0] CFG_WIDTH_CODE     = 3'd0;
    localparam logic [2:0] CFG_BIG_ENDIAN     = 3'd1;
    localparam logic [2:0] CFG_UNSIGNED_EIGHT = 3'd2;
    localparam logic [2:0] CFG_CHANNEL_COUNT  = 3'd3;
    localparam logic [2:0] CFG_CHANNEL_ORDER  = 3'd4;
    localparam logic [2:0] CFG_FRAME_LIMIT    = 3'd5;

    localparam logic [1:0]  RST_WIDTH_CODE    = 2'd1;
    localparam logic [3:0]  RST_CHANNEL_COUNT = 4'd2;
    localparam logic [23:0] RST_CHANNEL_ORDER = 24'd16434824;

    // Effective settings, already limited to what the hardware supports
    typedef struct packed {
        logic [1:0]  nbytes;
        logic        big_endian;
        logic        unsigned_eight;
        logic [3:0]  nch;
        logic [23:0] channel_order;
        logic [31:0] frame_limit;
    } cfg_t;

    typedef struct packed {
        logic emitting;
        logic frame_done;
    } stat_t;

    // Byte lane in the Q0.23 word for byte k of an nbytes-wide sample
    function automatic logic [1:0] byte_lane(logic [1:0] k, logic [1:0] nbytes, logic big);
        logic [1:0] lane;
        if (big) begin
            lane = 2'd2 - k;
        end else begin
            lane = k + 2'd3 - nbytes;
        end
        return lane;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/pcm_frame_unpacker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Interleaved PCM byte stream to per-channel Q0.23 samples.
// Input channel s_*: one raw stream byte per word in s_tdata.
// Output channel m_*: one sample per word; the last sample of a frame has tlast.
// Configuration channel cfg_*: register index and data, always accepted;
// write it only while no frame is being emitted.
// Bytes are taken one per cycle and written into the frame store at the
// current frame position. The word that completes a frame starts emission;
// input is held off (s_tready low) until the last output channel is pushed
// into the output register. Each output channel goes through setup, one
// store read per byte on the single read port, read return and a push to
// the output register; a channel whose source is outside the frame goes
// from setup straight to the push.
// A frame past the frame limit is collected but produces no words.
// Output stalls only hold the push; the output register decouples the
// sides. Reset clears the frame position, frame count and output valid
// and restores the default settings; the frame store is not cleared.
module pcm_frame_unpacker_core #(
    parameter int MAX_CHANNELS     = 8,
    parameter int MAX_SAMPLE_BYTES = 3
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // [23:0] sample (signed Q0.23)
    output logic      [2:0]  m_tuser,   // [2:0] out_channel
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import pfu_pkg::*;

    localparam int STORE_DEPTH = MAX_CHANNELS * MAX_SAMPLE_BYTES;
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    cfg_t          cfg;
    stat_t         stat;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    pfu_cfg #(
        .MAX_CHANNELS     (MAX_CHANNELS),
        .MAX_SAMPLE_BYTES (MAX_SAMPLE_BYTES)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pfu_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pfu_seq #(
        .MAX_CHANNELS     (MAX_CHANNELS),
        .MAX_SAMPLE_BYTES (MAX_SAMPLE_BYTES)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .stat      (stat)
    );

`ifndef ASSERT_OFF
    // The store must not take a byte while a frame is being read out
    a_no_write_while_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !stat.emitting)
        else $error("frame store written during emission");

    // Emission starts only from a completed frame
    a_emit_from_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(stat.emitting) |-> $past(stat.frame_done))
        else $error("emission started without a completed frame");

    // Frame completion happens only on an accepted byte
    a_done_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.frame_done |-> (s_tvalid && s_tready))
        else $error("frame completed without an input word");

    // The frame-closing word carries the last channel position
    a_last_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |-> (m_tuser == 3'(cfg.nch - 4'd1)))
        else $error("tlast on wrong channel position");
`endif

endmodule
`default_nettype wire

FILE: rtl/pfu_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module pfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 24,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/pfu_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
module pfu_cfg #(
    parameter int MAX_CHANNELS     = 8,
    parameter int MAX_SAMPLE_BYTES = 3
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output pfu_pkg::cfg_t    cfg
);
    import pfu_pkg::*;

    logic [1:0]  width_code_reg;
    logic        big_endian_reg;
    logic        unsigned_eight_reg;
    logic [3:0]  channel_count_reg;
    logic [23:0] channel_order_reg;
    logic [31:0] frame_limit_reg;

    logic [2:0] bytes_eff;
    logic [3:0] chans_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_code_reg     <= RST_WIDTH_CODE;
            big_endian_reg     <= 1'b0;
            unsigned_eight_reg <= 1'b0;
            channel_count_reg  <= RST_CHANNEL_COUNT;
            channel_order_reg  <= RST_CHANNEL_ORDER;
            frame_limit_reg    <= 32'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_WIDTH_CODE:     width_code_reg     <= cfg_data[1:0];
                CFG_BIG_ENDIAN:     big_endian_reg     <= cfg_data[0];
                CFG_UNSIGNED_EIGHT: unsigned_eight_reg <= cfg_data[0];
                CFG_CHANNEL_COUNT:  channel_count_reg  <= cfg_data[3:0];
                CFG_CHANNEL_ORDER:  channel_order_reg  <= cfg_data[23:0];
                CFG_FRAME_LIMIT:    frame_limit_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        bytes_eff = 3'(width_code_reg) + 3'd1;
        if (bytes_eff > 3'd3) begin
            bytes_eff = 3'd3;
        end
        if (32'(bytes_eff) > 32'(MAX_SAMPLE_BYTES)) begin
            bytes_eff = 3'(MAX_SAMPLE_BYTES);
        end

        chans_eff = channel_count_reg;
        if (chans_eff == 4'd0) begin
            chans_eff = 4'd1;
        end
        if (32'(chans_eff) > 32'(MAX_CHANNELS)) begin
            chans_eff = 4'(MAX_CHANNELS);
        end

        cfg.nbytes         = bytes_eff[1:0];
        cfg.big_endian     = big_endian_reg;
        cfg.unsigned_eight = unsigned_eight_reg;
        cfg.nch            = chans_eff;
        cfg.channel_order  = channel_order_reg;
        cfg.frame_limit    = frame_limit_reg;
    end

endmodule
`default_nettype wire

FILE: rtl/pfu_seq.sv
`timescale 1ns / 1ps
`default_nettype none
module pfu_seq #(
    parameter int MAX_CHANNELS     = 8,
    parameter int MAX_SAMPLE_BYTES = 3,
    localparam int STORE_DEPTH = MAX_CHANNELS * MAX_SAMPLE_BYTES,
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire pfu_pkg::cfg_t  cfg,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [7:0]     s_tdata,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic      [23:0]    m_tdata,
    output logic      [2:0]     m_tuser,
    output logic                m_tlast,
    output logic                ram_we,
    output logic      [AW-1:0]  ram_waddr,
    output logic      [7:0]     ram_wdata,
    output logic      [AW-1:0]  ram_raddr,
    input  wire logic [7:0]     ram_rdata,
    output pfu_pkg::stat_t      stat
);
    import pfu_pkg::*;

    localparam int PW = $clog2(STORE_DEPTH + 1);
    localparam int IDX_W = ($clog2(MAX_CHANNELS) > 3) ? $clog2(MAX_CHANNELS) : 3;

    state_t state_reg, state_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [31:0]      done_reg, done_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [1:0]       k_reg, k_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [23:0]      acc_reg, acc_next;
    logic             rd_pend_reg, rd_pend_next;
    logic [1:0]       rd_lane_reg, rd_lane_next;
    logic             m_valid_reg, m_valid_next;
    logic [23:0]      m_sample_reg, m_sample_next;
    logic [2:0]       m_chan_reg, m_chan_next;
    logic             m_last_reg, m_last_next;

    logic [2:0]       order_ent [8];
    logic [IDX_W-1:0] src;
    logic             src_ok;
    logic             j_last;
    logic             k_last;
    logic [5:0]       frame_bytes;
    logic [31:0]      pos_inc;
    logic             pass;
    logic             in_acc;
    logic             frame_done;
    logic [7:0]       rd_byte;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            order_ent[i] = cfg.channel_order[3*i +: 3];
        end
    end

    assign src = (32'(j_reg) < 32'd8) ? IDX_W'(order_ent[j_reg[2:0]]) : j_reg;
    assign src_ok      = 32'(src) < 32'(cfg.nch);
    assign j_last      = (32'(j_reg) + 32'd1) == 32'(cfg.nch);
    assign k_last      = k_reg == (cfg.nbytes - 2'd1);
    assign frame_bytes = 6'(cfg.nch) * 6'(cfg.nbytes);
    assign pos_inc     = 32'(pos_reg) + 32'd1;
    assign pass        = (cfg.frame_limit == 32'd0) || (done_reg < cfg.frame_limit);

    assign s_tready  = state_reg == ST_COLLECT;
    assign in_acc    = s_tvalid && s_tready;
    assign ram_we    = in_acc;
    assign ram_waddr = pos_reg[AW-1:0];
    assign ram_wdata = s_tdata;
    assign ram_raddr = addr_reg;

    // Offset-binary 8-bit codes flip the top bit to become two's complement
    assign rd_byte = (cfg.nbytes == 2'd1 && cfg.unsigned_eight) ? (ram_rdata ^ 8'h80)
                                                                 : ram_rdata;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_sample_reg;
    assign m_tuser  = m_chan_reg;
    assign m_tlast  = m_last_reg;

    assign stat.emitting   = state_reg != ST_COLLECT;
    assign stat.frame_done = frame_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_COLLECT;
            pos_reg     <= '0;
            done_reg    <= 32'd0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            done_reg    <= done_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
        j_reg        <= j_next;
        k_reg        <= k_next;
        addr_reg     <= addr_next;
        acc_reg      <= acc_next;
        rd_lane_reg  <= rd_lane_next;
        m_sample_reg <= m_sample_next;
        m_chan_reg   <= m_chan_next;
        m_last_reg   <= m_last_next;
    end

    always_comb begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        done_next     = done_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        addr_next     = addr_reg;
        acc_next      = acc_reg;
        rd_pend_next  = 1'b0;
        rd_lane_next  = rd_lane_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_sample_next = m_sample_reg;
        m_chan_next   = m_chan_reg;
        m_last_next   = m_last_reg;
        frame_done    = 1'b0;

        // Land the byte read in the previous cycle in its lane
        if (rd_pend_reg) begin
            case (rd_lane_reg)
                2'd0:    acc_next[7:0]   = rd_byte;
                2'd1:    acc_next[15:8]  = rd_byte;
                default: acc_next[23:16] = rd_byte;
            endcase
        end

        case (state_reg)
            ST_COLLECT: begin
                if (in_acc) begin
                    if (pos_inc >= 32'(frame_bytes)) begin
                        pos_next   = '0;
                        frame_done = 1'b1;
                        if (pass) begin
                            done_next  = done_reg + 32'd1;
                            j_next     = '0;
                            state_next = ST_SETUP;
                        end
                    end else begin
                        pos_next = PW'(pos_inc);
                    end
                end
            end
            ST_SETUP: begin
                acc_next = 24'd0;
                k_next   = 2'd0;
                if (src_ok) begin
                    addr_next  = AW'(32'(src) * 32'(cfg.nbytes));
                    state_next = ST_READ;
                end else begin
                    state_next = ST_PUSH;
                end
            end
            ST_READ: begin
                rd_pend_next = 1'b1;
                rd_lane_next = byte_lane(k_reg, cfg.nbytes, cfg.big_endian);
                addr_next    = addr_reg + AW'(1);
                k_next       = k_reg + 2'd1;
                if (k_last) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                // Hold until the output word is free or being taken
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_sample_next = acc_reg;
                    m_chan_next   = j_reg[2:0];
                    m_last_next   = j_last;
                    if (j_last) begin
                        state_next = ST_COLLECT;
                    end else begin
                        j_next     = j_reg + IDX_W'(1);
                        state_next = ST_SETUP;
                    end
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

endmodule
`default_nettype wire
